// ===== hdl/sre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample rate estimator package
// Shared widths, constants, register indexes and types of the estimator.
// ----------------------------------------------------------------------------
package sre_pkg;

  // Number of intervals held in the sliding window.
  localparam int unsigned Window = 16;

  localparam int unsigned TsW    = 48;
  localparam int unsigned PtrW   = $clog2(Window);
  localparam int unsigned SkipW  = $clog2(Window + 1);
  localparam int unsigned ElapW  = TsW + PtrW + 1;
  localparam int unsigned CountW = $clog2(Window + 256 + 1);
  localparam int unsigned WarmW  = 8;
  localparam int unsigned FreqW  = 28;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 48;

  // 1e6 Hz per microsecond, times 256 for the Q.8 fraction.
  localparam longint unsigned ScaleQ8 = 64'd256000000;
  localparam int unsigned NumW = $clog2(ScaleQ8 * Window + 1);
  localparam int unsigned DivCntW = $clog2(NumW + 1);

  localparam logic [CountW-1:0] CountMax = CountW'(Window + 256);

  localparam logic [TsW-1:0]   ThresholdReset = TsW'(5000000);
  localparam logic [WarmW-1:0] WarmupReset    = WarmW'(10);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOutlierThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWarmupExtra      = CfgIdxW'(1);

  typedef struct packed {
    logic           skip;
    logic [TsW-1:0] span;
  } entry_t;

  // Step strobes from the sequencer to the window.
  typedef struct packed {
    logic load;
    logic retire;
    logic commit;
  } win_ctrl_t;

  // Window totals seen by the sequencer.
  typedef struct packed {
    logic [SkipW-1:0]  skip_total;
    logic [ElapW-1:0]  elapsed;
    logic [CountW-1:0] count;
  } win_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_COMMIT,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/sre_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample rate estimator channels
// Valid/ready channels for timestamps, results and configuration writes.
// ----------------------------------------------------------------------------
interface sre_sample_if;
  logic                       valid;
  logic                       ready;
  logic [sre_pkg::TsW-1:0]    timestamp_us;

  modport source (output valid, output timestamp_us, input ready);
  modport sink   (input valid, input timestamp_us, output ready);
endinterface

interface sre_result_if;
  logic                        valid;
  logic                        ready;
  logic                        estimate_ready;
  logic [sre_pkg::FreqW-1:0]   freq_hz_q8;
  logic [sre_pkg::SkipW-1:0]   skipped_count;

  modport source (output valid, output estimate_ready, output freq_hz_q8,
                  output skipped_count, input ready);
  modport sink   (input valid, input estimate_ready, input freq_hz_q8,
                  input skipped_count, output ready);
endinterface

interface sre_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sre_pkg::CfgIdxW-1:0]   index;
  logic [sre_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sample_rate_estimator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample rate estimator
// Sliding-window estimate of a sensor's sample rate from its timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one microsecond timestamp per sensor sample. Each
//   transfer on it produces exactly one transfer on result_o with the ready
//   flag, the rate in Hz as unsigned Q.8 and the count of skipped intervals
//   in the window. cfg_i writes the outlier threshold (index 0) and the
//   warm-up extra count (index 1); it is always ready and should be used
//   only while no sample is in flight.
//   The numerator is 32 bits wide for a 16-interval window. Three steps
//   (load, retire, commit) update the interval ring and its totals, a
//   prepare state loads the divider, and the bit-serial divider then gives
//   one quotient bit per cycle; the result register loads once it is free.
//   The divider sets the throughput; the block takes one sample at a time.
//   The result sits in an output register, so when the receiver stalls the
//   next sample is still taken and worked on; only the handoff of its result
//   waits until the register is free.
//   Reset clears the ring, the totals, the sample count and the previous
//   timestamp, and restores both configuration registers to their defaults.
// ----------------------------------------------------------------------------
module sample_rate_estimator_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  sre_sample_if.sink            sample_i,
  sre_result_if.source          result_o,
  sre_cfg_if.sink               cfg_i
);

  sre_pkg::state_e                state_q, state_d;
  sre_pkg::win_ctrl_t             win_ctrl;
  sre_pkg::win_stat_t             win_stat;

  logic [sre_pkg::TsW-1:0]        threshold_q;
  logic [sre_pkg::WarmW-1:0]      warmup_q;

  logic                           sample_xfer;
  logic                           div_start;
  logic                           div_done;
  logic [sre_pkg::NumW-1:0]       numerator;
  logic [sre_pkg::NumW-1:0]       quotient;
  logic [sre_pkg::SkipW-1:0]      live_count;
  logic [sre_pkg::CountW-1:0]     ready_limit;
  logic                           est_ready;
  logic [sre_pkg::FreqW-1:0]      freq;
  logic                           out_load;

  logic                           out_valid_q;
  logic                           out_ready_q;
  logic [sre_pkg::FreqW-1:0]      out_freq_q;
  logic [sre_pkg::SkipW-1:0]      out_skip_q;

  // Configuration registers. Writes beyond the register list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= sre_pkg::ThresholdReset;
      warmup_q    <= sre_pkg::WarmupReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sre_pkg::RegOutlierThreshold: threshold_q <= cfg_i.data[sre_pkg::TsW-1:0];
        sre_pkg::RegWarmupExtra:      warmup_q    <= cfg_i.data[sre_pkg::WarmW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: ring update in three steps, then the serial division.
  assign sample_xfer = sample_i.valid && sample_i.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sre_pkg::ST_IDLE:   if (sample_xfer) state_d = sre_pkg::ST_RETIRE;
      sre_pkg::ST_RETIRE: state_d = sre_pkg::ST_COMMIT;
      sre_pkg::ST_COMMIT: state_d = sre_pkg::ST_PREP;
      sre_pkg::ST_PREP:   state_d = sre_pkg::ST_DIV;
      sre_pkg::ST_DIV:    if (div_done) state_d = sre_pkg::ST_DONE;
      sre_pkg::ST_DONE:   if (!out_valid_q || result_o.ready) state_d = sre_pkg::ST_IDLE;
      default:            state_d = sre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready  = 1'b0;
    win_ctrl        = '0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      sre_pkg::ST_IDLE: begin
        sample_i.ready = 1'b1;
        win_ctrl.load  = sample_i.valid;
      end
      sre_pkg::ST_RETIRE: win_ctrl.retire = 1'b1;
      sre_pkg::ST_COMMIT: win_ctrl.commit = 1'b1;
      sre_pkg::ST_PREP:   div_start       = 1'b1;
      sre_pkg::ST_DIV:    ;
      sre_pkg::ST_DONE:   out_load = !out_valid_q || result_o.ready;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  sre_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (win_ctrl),
    .ts_i        (sample_i.timestamp_us),
    .threshold_i (threshold_q),
    .stat_o      (win_stat)
  );

  // Numerator: 256e6 times the number of intervals that were not skipped.
  // The factor is at most the window size, so this is a small constant
  // product.
  always_comb begin
    live_count = sre_pkg::SkipW'(sre_pkg::Window) - win_stat.skip_total;
    numerator  = sre_pkg::NumW'(sre_pkg::NumW'(sre_pkg::ScaleQ8) *
                                sre_pkg::NumW'(live_count));
  end

  sre_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numerator),
    .den_i   (win_stat.elapsed),
    .done_o  (div_done),
    .quot_o  (quotient)
  );

  // Result shaping. The estimate is valid once the sample count passes the
  // window size plus the warm-up extra. With every interval skipped, or no
  // elapsed time at all, the rate reads zero; an overlarge quotient
  // saturates.
  always_comb begin
    ready_limit = sre_pkg::CountW'(sre_pkg::Window) + sre_pkg::CountW'(warmup_q);
    est_ready   = win_stat.count > ready_limit;
    if (!est_ready || (win_stat.skip_total >= sre_pkg::SkipW'(sre_pkg::Window)) ||
        (win_stat.elapsed == '0)) begin
      freq = '0;
    end else if (|quotient[sre_pkg::NumW-1:sre_pkg::FreqW]) begin
      freq = '1;
    end else begin
      freq = quotient[sre_pkg::FreqW-1:0];
    end
  end

  // Output register: holds a finished result while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ready_q <= est_ready;
      out_freq_q  <= freq;
      out_skip_q  <= est_ready ? win_stat.skip_total : '0;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.estimate_ready = out_ready_q;
  assign result_o.freq_hz_q8     = out_freq_q;
  assign result_o.skipped_count  = out_skip_q;

endmodule
`default_nettype wire

// ===== hdl/sre_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample rate estimator window
// Interval ring with running elapsed and skip totals, updated in three steps.
// ----------------------------------------------------------------------------
module sre_window (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sre_pkg::win_ctrl_t        ctrl_i,
  input  wire logic [sre_pkg::TsW-1:0]   ts_i,
  input  wire logic [sre_pkg::TsW-1:0]   threshold_i,
  output sre_pkg::win_stat_t             stat_o
);

  sre_pkg::entry_t               ring_q [sre_pkg::Window];
  sre_pkg::entry_t               entry_q, entry_d, old_entry;
  logic [sre_pkg::PtrW-1:0]      ptr_q;
  logic [sre_pkg::TsW-1:0]       last_q, ts_q, dt;
  logic [sre_pkg::CountW-1:0]    count_q;
  logic [sre_pkg::ElapW-1:0]     elapsed_q;
  logic [sre_pkg::SkipW-1:0]     skip_q;
  logic                          first_q;
  logic                          newer;

  // Classify the incoming interval.
  always_comb begin
    newer         = ts_i > last_q;
    dt            = ts_i - last_q;
    entry_d.span  = newer ? dt : '0;
    entry_d.skip  = !newer || (dt > threshold_i);
  end

  assign old_entry = ring_q[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(sre_pkg::Window); i++) begin
        ring_q[i] <= '0;
      end
      ptr_q     <= '0;
      last_q    <= '0;
      count_q   <= '0;
      elapsed_q <= '0;
      skip_q    <= '0;
      first_q   <= 1'b0;
      entry_q   <= '0;
      ts_q      <= '0;
    end else begin
      if (ctrl_i.load) begin
        entry_q <= entry_d;
        ts_q    <= ts_i;
        first_q <= (count_q == '0);
      end
      // Take the oldest interval out of the totals.
      if (ctrl_i.retire && !first_q) begin
        elapsed_q <= elapsed_q - sre_pkg::ElapW'(old_entry.span);
        skip_q    <= skip_q - sre_pkg::SkipW'(old_entry.skip);
      end
      if (ctrl_i.commit) begin
        if (!first_q) begin
          ring_q[ptr_q] <= entry_q;
          elapsed_q     <= elapsed_q + sre_pkg::ElapW'(entry_q.span);
          skip_q        <= skip_q + sre_pkg::SkipW'(entry_q.skip);
          ptr_q         <= (ptr_q == sre_pkg::PtrW'(sre_pkg::Window - 1)) ? '0
                                                                          : ptr_q + 1'b1;
        end
        last_q <= ts_q;
        if (count_q < sre_pkg::CountMax) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.skip_total = skip_q;
  assign stat_o.elapsed    = elapsed_q;
  assign stat_o.count      = count_q;

endmodule
`default_nettype wire

// ===== hdl/sre_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample rate estimator divider
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sre_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [sre_pkg::NumW-1:0]     num_i,
  input  wire logic [sre_pkg::ElapW-1:0]    den_i,
  output logic                              done_o,
  output logic [sre_pkg::NumW-1:0]          quot_o
);

  // The numerator shifts out of the top of acc_q while quotient bits
  // shift in at the bottom.
  logic [sre_pkg::NumW-1:0]    acc_q, acc_d;
  logic [sre_pkg::ElapW-1:0]   rem_q, rem_d, den_q;
  logic [sre_pkg::ElapW:0]     rem_sh;
  logic [sre_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        fits;

  always_comb begin
    rem_sh = {rem_q, acc_q[sre_pkg::NumW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_d  = fits ? sre_pkg::ElapW'(rem_sh - {1'b0, den_q})
                  : sre_pkg::ElapW'(rem_sh);
    acc_d  = {acc_q[sre_pkg::NumW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= sre_pkg::DivCntW'(sre_pkg::NumW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != sre_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == sre_pkg::DivCntW'(1));
  assign quot_o = acc_q;

endmodule
`default_nettype wire

// ===== hdl/sre_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample rate estimator checker
// Port-level properties of the estimator, bound to its top level.
// ----------------------------------------------------------------------------
module sre_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic                        est_ready_i,
  input  wire logic [sre_pkg::FreqW-1:0]   freq_i,
  input  wire logic [sre_pkg::SkipW-1:0]   skip_i
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(est_ready_i) && $stable(freq_i) && $stable(skip_i))
    else $error("stalled result changed");

  // Before the warm-up completes the result fields read zero.
  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !est_ready_i |-> (freq_i == '0) && (skip_i == '0))
    else $error("result fields set while estimate not ready");

  // The skip count never exceeds the window, and a rate needs a live interval.
  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (skip_i <= sre_pkg::SkipW'(sre_pkg::Window)) &&
      ((freq_i == '0) || (skip_i < sre_pkg::SkipW'(sre_pkg::Window))))
    else $error("skip count out of range");

  // One sample at a time: after a timestamp transfer the input closes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while one is in flight");

endmodule

bind sample_rate_estimator_unit sre_checker u_sre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .est_ready_i (result_o.estimate_ready),
  .freq_i      (result_o.freq_hz_q8),
  .skip_i      (result_o.skipped_count)
);
`default_nettype wire
